>>> src/msis_pkg.sv
package msis_pkg;

  // Width of every stored and reported sum; sums saturate at the top code.
  localparam int unsigned SUM_W = 26;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef logic [SUM_W-1:0] sum_t;

endpackage

>>> src/msis_in_if.sv
interface msis_in_if #(
  parameter int unsigned VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

>>> src/msis_out_if.sv
interface msis_out_if;
  import msis_pkg::*;

  logic valid;
  logic ready;
  sum_t ending_sum;
  sum_t best_sum;
  logic overflow;
  logic done_res;

  modport source (output valid, output ending_sum, output best_sum, output overflow,
                  output done_res, input ready);
  modport sink   (input valid, input ending_sum, input best_sum, input overflow,
                  input done_res, output ready);
endinterface

>>> src/msis_ram.sv
module msis_ram #(
  parameter int unsigned WIDTH = 42,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> src/max_sum_increasing_subsequence.sv
// Maximum-sum strictly increasing subsequence. Each input transaction carries
// one element of a sequence; the result transaction gives the largest sum of a
// strictly increasing subsequence ending at that element and the best such sum
// so far. A transaction with last set closes the sequence: its result still
// shows the best sum, after which length and best are cleared. Elements beyond
// MAX_LEN are flagged with overflow and leave the state untouched. Elements and
// their ending sums live in one memory with a single registered read port,
// which is swept one entry per cycle: an element scans every earlier element
// of its sequence, then drains the last read, then waits until the result
// register is free (an overflowed element and the first of a sequence skip
// the scan and drain); no new element is accepted until then. There is no
// clearing pass after reset; only entries written in the current sequence are
// ever read.
module max_sum_increasing_subsequence #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  msis_in_if.sink           in_ch,
  msis_out_if.source        out_ch
);
  import msis_pkg::*;

  localparam int unsigned IDX_W   = $clog2(MAX_LEN);
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned ENTRY_W = VALUE_BITS + SUM_W;
  localparam int unsigned ADD_W   = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  sum_t                  best_r, best_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic                  pend_r, pend_nxt;
  logic [VALUE_BITS-1:0] v_r, v_nxt;
  logic                  last_r, last_nxt;
  logic                  ovf_r, ovf_nxt;
  sum_t                  best_prev_r, best_prev_nxt;

  logic                  out_valid_r, out_valid_nxt;
  sum_t                  out_ending_r, out_ending_nxt;
  sum_t                  out_best_r, out_best_nxt;
  logic                  out_ovf_r, out_ovf_nxt;
  logic                  out_done_r, out_done_nxt;

  logic                  rd_en;
  logic [ENTRY_W-1:0]    rd_data;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] rd_val;
  sum_t                  rd_sum;
  logic [ADD_W-1:0]      raw_sum;
  sum_t                  ending;
  sum_t                  best_upd;
  logic                  done_fire;

  msis_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_LEN)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (len_r[IDX_W-1:0]),
    .wdata ({v_r, ending}),
    .re    (rd_en),
    .raddr (cnt_r),
    .rdata (rd_data)
  );

  assign rd_val = rd_data[SUM_W +: VALUE_BITS];
  assign rd_sum = rd_data[SUM_W-1:0];

  assign raw_sum  = ADD_W'(v_r) + ADD_W'(best_prev_r);
  assign ending   = ovf_r ? '0 :
                    ((raw_sum > ADD_W'(SUM_MAX)) ? SUM_MAX : raw_sum[SUM_W-1:0]);
  assign best_upd = (ending > best_r) ? ending : best_r;

  assign done_fire = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign wr_en     = done_fire && !ovf_r;
  assign rd_en     = (state_r == S_SCAN);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ending_sum = out_ending_r;
  assign out_ch.best_sum   = out_best_r;
  assign out_ch.overflow   = out_ovf_r;
  assign out_ch.done_res   = out_done_r;

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    best_nxt       = best_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = (state_r == S_SCAN);
    v_nxt          = v_r;
    last_nxt       = last_r;
    ovf_nxt        = ovf_r;
    best_prev_nxt  = best_prev_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_ending_nxt = out_ending_r;
    out_best_nxt   = out_best_r;
    out_ovf_nxt    = out_ovf_r;
    out_done_nxt   = out_done_r;

    // Read data is registered, so it arrives in the cycle after its address was issued.
    if (pend_r && (rd_val < v_r) && (rd_sum > best_prev_r)) begin
      best_prev_nxt = rd_sum;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          v_nxt         = in_ch.value;
          last_nxt      = in_ch.last;
          ovf_nxt       = (len_r == LEN_W'(MAX_LEN));
          best_prev_nxt = '0;
          cnt_nxt       = '0;
          if ((len_r == LEN_W'(MAX_LEN)) || (len_r == '0)) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (LEN_W'(cnt_r) == len_r - LEN_W'(1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_fire) begin
          out_valid_nxt  = 1'b1;
          out_ending_nxt = ending;
          out_best_nxt   = best_upd;
          out_ovf_nxt    = ovf_r;
          out_done_nxt   = last_r;
          if (last_r) begin
            len_nxt  = '0;
            best_nxt = '0;
          end else begin
            len_nxt  = ovf_r ? len_r : len_r + LEN_W'(1);
            best_nxt = best_upd;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      best_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      best_r      <= best_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cnt_r        <= cnt_nxt;
    v_r          <= v_nxt;
    last_r       <= last_nxt;
    ovf_r        <= ovf_nxt;
    best_prev_r  <= best_prev_nxt;
    out_ending_r <= out_ending_nxt;
    out_best_r   <= out_best_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_done_r   <= out_done_nxt;
  end

`ifndef SYNTH
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_LEN))
    else $error("sequence length beyond capacity");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (LEN_W'(cnt_r) < len_r))
    else $error("scan address past the stored elements");

  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (done_fire && last_r) |=> (len_r == '0 && best_r == '0))
    else $error("closing transaction did not clear the sequence");

  a_best_covers_ending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_best_r >= out_ending_r))
    else $error("reported best below the ending sum");

  a_overflow_no_sum: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ovf_r) |-> (out_ending_r == '0))
    else $error("ignored element reported a nonzero ending sum");
`endif

endmodule
